// ----- src/zcpc_pkg.sv -----
// ----------------------------------------------------------------------------
// zcpc_pkg
// shared widths, defaults and divider control types for the zero-crossing
// phase comparator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zcpc_pkg;

    // defaults handed to the top level parameters
    localparam int MAX_BLOCK_DEF   = 4096;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field and state widths
    localparam int IN_W   = 16;
    localparam int OUT_W  = 24;
    localparam int SUM_W  = 40;
    localparam int TIME_W = 32;
    localparam int STEP_W = 6;

    // divider request from the sequencer
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

// ----- src/zcpc_div.sv -----
// ----------------------------------------------------------------------------
// zcpc_div
// shared restoring divider, one quotient bit per cycle, left-aligned dividend
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zcpc_div #(
    parameter int DIV_W = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire zcpc_pkg::t_div_ctl        i_ctl,
    input  wire logic [zcpc_pkg::SUM_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]          i_divisor,
    output zcpc_pkg::t_div_sts             o_sts,
    output logic [zcpc_pkg::SUM_W-1:0]     o_quotient
);
    import zcpc_pkg::*;

    logic [DIV_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_dq;
    logic [DIV_W-1:0]  r_dsr;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W+1:0]  w_diff;
    logic              w_ge;
    logic [DIV_W-1:0]  n_rem;

    // trial subtract of the shifted partial remainder
    always_comb begin
        w_diff = {1'b0, r_rem, r_dq[SUM_W-1]} - {2'b00, r_dsr};
        w_ge   = ~w_diff[DIV_W+1];
        n_rem  = w_ge ? w_diff[DIV_W-1:0] : {r_rem[DIV_W-2:0], r_dq[SUM_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_rem  <= '0;
                r_dq   <= i_dividend;
                r_dsr  <= i_divisor;
                r_cnt  <= i_ctl.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dq  <= {r_dq[SUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_dq;

endmodule

`default_nettype wire

// ----- src/zero_crossing_phase_comparator.sv -----
// ----------------------------------------------------------------------------
// zero_crossing_phase_comparator
// rising zero-crossing period and delay averager for two sample channels
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_valid / o_ready) carries one word per sample pair:
//   i_sample_a, i_sample_b and i_last_in_block. output channel
//   (o_valid / i_ready) carries one result word per block, produced only
//   when the accepted word had i_last_in_block set.
//   every crossing time is interpolated by the shared serial divider. a word
//   with no crossing passes the a check, the b check and a finish step; each
//   channel that crosses adds a divide and its wait. the last word of a
//   block then adds three averaging divides (period a, period b, delay) and
//   the emit step.
//   o_ready is high only between words.
//   reset clears all sample history, crossing times, sums and counts and
//   drops o_valid.
//   the result sits in an output register; when the receiver stalls the
//   block keeps taking words and only holds in the emit step if a second
//   block result is ready before the first one has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zero_crossing_phase_comparator #(
    parameter int MAX_BLOCK   = zcpc_pkg::MAX_BLOCK_DEF,
    parameter int FRAC_BITS   = zcpc_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = zcpc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [zcpc_pkg::IN_W-1:0]  i_sample_a,
    input  wire logic signed [zcpc_pkg::IN_W-1:0]  i_sample_b,
    input  wire logic                              i_last_in_block,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [zcpc_pkg::OUT_W-1:0]             o_avg_period_a,
    output logic [zcpc_pkg::OUT_W-1:0]             o_avg_period_b,
    output logic signed [zcpc_pkg::OUT_W-1:0]      o_avg_delay,
    output logic                                   o_period_a_valid,
    output logic                                   o_period_b_valid,
    output logic                                   o_delay_valid
);
    import zcpc_pkg::*;

    // count saturates at 2*MAX_BLOCK-1
    localparam int CW = $clog2(2 * MAX_BLOCK);
    localparam logic [CW-1:0] COUNT_MAX = CW'(2 * MAX_BLOCK - 1);
    // divisor must hold either a sample difference or a count
    localparam int VW = (SAMPLE_BITS > CW) ? SAMPLE_BITS : CW;
    localparam logic [STEP_W-1:0] FRAC_STEPS = STEP_W'(SAMPLE_BITS + FRAC_BITS);
    localparam logic [STEP_W-1:0] AVG_STEPS  = STEP_W'(SUM_W);
    localparam int ALIGN = SUM_W - SAMPLE_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CROSS_A,
        S_WAIT_A,
        S_CROSS_B,
        S_WAIT_B,
        S_FINISH,
        S_AVG_A,
        S_WAIT_PA,
        S_AVG_B,
        S_WAIT_PB,
        S_AVG_D,
        S_WAIT_DL,
        S_EMIT
    } t_state;

    t_state r_state;

    // sample history and current word
    logic signed [SAMPLE_BITS-1:0] r_prev_a, r_prev_b;
    logic signed [SAMPLE_BITS-1:0] r_cur_a, r_cur_b;
    logic                          r_last;

    // crossing times, fixed point with FRAC_BITS fraction bits
    logic [TIME_W-1:0] r_time;
    logic [TIME_W-1:0] r_lat_a, r_ear_a, r_lat_b, r_ear_b;

    // block accumulators
    logic [SUM_W-1:0]        r_sum_a, r_sum_b;
    logic signed [SUM_W-1:0] r_sum_d;
    logic [CW-1:0]           r_cnt_a, r_cnt_b, r_cnt_d;

    // averages waiting for the emit step
    logic [OUT_W-1:0] r_pa, r_pb, r_dl;

    // output register
    logic             r_o_valid;
    logic [OUT_W-1:0] r_o_pa, r_o_pb, r_o_dl;
    logic             r_o_va, r_o_vb, r_o_vd;

    // sample narrowing: low SAMPLE_BITS taken, zero fill above the field
    logic [SAMPLE_BITS+IN_W-1:0] w_ext_a, w_ext_b;
    assign w_ext_a = {{SAMPLE_BITS{1'b0}}, i_sample_a};
    assign w_ext_b = {{SAMPLE_BITS{1'b0}}, i_sample_b};

    // crossing detect: previous negative, current not negative
    logic w_xa, w_xb;
    assign w_xa = r_prev_a[SAMPLE_BITS-1] & ~r_cur_a[SAMPLE_BITS-1];
    assign w_xb = r_prev_b[SAMPLE_BITS-1] & ~r_cur_b[SAMPLE_BITS-1];

    // interpolation operands: -prev and cur - prev, both positive on a crossing
    logic [SAMPLE_BITS-1:0] w_np_a, w_np_b;
    logic [SAMPLE_BITS:0]   w_den_a, w_den_b;
    assign w_np_a  = SAMPLE_BITS'(-r_prev_a);
    assign w_np_b  = SAMPLE_BITS'(-r_prev_b);
    assign w_den_a = {r_cur_a[SAMPLE_BITS-1], r_cur_a} - {r_prev_a[SAMPLE_BITS-1], r_prev_a};
    assign w_den_b = {r_cur_b[SAMPLE_BITS-1], r_cur_b} - {r_prev_b[SAMPLE_BITS-1], r_prev_b};

    // saturating period adds
    logic [SUM_W:0]   w_ps_a, w_ps_b;
    logic [SUM_W-1:0] n_sum_a, n_sum_b;
    assign w_ps_a  = {1'b0, r_sum_a} + (SUM_W + 1)'(r_lat_a - r_ear_a);
    assign w_ps_b  = {1'b0, r_sum_b} + (SUM_W + 1)'(r_lat_b - r_ear_b);
    assign n_sum_a = w_ps_a[SUM_W] ? {SUM_W{1'b1}} : w_ps_a[SUM_W-1:0];
    assign n_sum_b = w_ps_b[SUM_W] ? {SUM_W{1'b1}} : w_ps_b[SUM_W-1:0];

    // saturating delay add, delay is b's old crossing minus a's newest
    logic [TIME_W-1:0] w_d;
    logic [SUM_W:0]    w_ds;
    logic [SUM_W-1:0]  n_sum_d;
    assign w_d  = r_lat_b - r_lat_a;
    assign w_ds = {r_sum_d[SUM_W-1], r_sum_d}
                + {{(SUM_W + 1 - TIME_W){w_d[TIME_W-1]}}, w_d};
    always_comb begin
        if (w_ds[SUM_W] != w_ds[SUM_W-1]) begin
            n_sum_d = w_ds[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_sum_d = w_ds[SUM_W-1:0];
        end
    end

    // magnitude of the delay sum for the unsigned divider
    logic [SUM_W-1:0] w_mag_d;
    assign w_mag_d = r_sum_d[SUM_W-1] ? SUM_W'(-r_sum_d) : SUM_W'(r_sum_d);

    // shared divider hookup
    t_div_ctl         w_div_ctl;
    t_div_sts         w_div_sts;
    logic [SUM_W-1:0] w_div_dvd;
    logic [VW-1:0]    w_div_dsr;
    logic [SUM_W-1:0] w_quo;

    always_comb begin
        w_div_ctl.start = 1'b0;
        w_div_ctl.steps = FRAC_STEPS;
        w_div_dvd       = SUM_W'(w_np_a) << ALIGN;
        w_div_dsr       = VW'(w_den_a[SAMPLE_BITS-1:0]);
        unique case (r_state)
            S_CROSS_A: begin
                w_div_ctl.start = w_xa;
            end
            S_CROSS_B: begin
                w_div_ctl.start = w_xb;
                w_div_dvd       = SUM_W'(w_np_b) << ALIGN;
                w_div_dsr       = VW'(w_den_b[SAMPLE_BITS-1:0]);
            end
            S_AVG_A: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.steps = AVG_STEPS;
                w_div_dvd       = r_sum_a;
                w_div_dsr       = VW'(r_cnt_a);
            end
            S_AVG_B: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.steps = AVG_STEPS;
                w_div_dvd       = r_sum_b;
                w_div_dsr       = VW'(r_cnt_b);
            end
            S_AVG_D: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.steps = AVG_STEPS;
                w_div_dvd       = w_mag_d;
                w_div_dsr       = VW'(r_cnt_d);
            end
            default: begin
            end
        endcase
    end

    zcpc_div #(
        .DIV_W(VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_sts      (w_div_sts),
        .o_quotient (w_quo)
    );

    // crossing time = sample time plus interpolated fraction
    logic [TIME_W-1:0] w_tbase, w_tcross;
    assign w_tbase  = TIME_W'(r_time << FRAC_BITS);
    assign w_tcross = w_tbase + w_quo[TIME_W-1:0];

    // average saturation
    logic [OUT_W-1:0] w_sat_u, w_sat_d;
    logic             w_neg_big;
    assign w_sat_u   = (|w_quo[SUM_W-1:OUT_W]) ? {OUT_W{1'b1}} : w_quo[OUT_W-1:0];
    assign w_neg_big = (|w_quo[SUM_W-1:OUT_W])
                     || (w_quo[OUT_W-1] && (|w_quo[OUT_W-2:0]));
    always_comb begin
        if (r_sum_d[SUM_W-1]) begin
            w_sat_d = w_neg_big ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-w_quo[OUT_W-1:0]);
        end else begin
            w_sat_d = (|w_quo[SUM_W-1:OUT_W-1]) ? {1'b0, {(OUT_W-1){1'b1}}}
                                                 : w_quo[OUT_W-1:0];
        end
    end

    logic w_out_free;
    assign w_out_free = ~r_o_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prev_a  <= '0;
            r_prev_b  <= '0;
            r_time    <= '0;
            r_lat_a   <= '0;
            r_ear_a   <= '0;
            r_lat_b   <= '0;
            r_ear_b   <= '0;
            r_sum_a   <= '0;
            r_sum_b   <= '0;
            r_sum_d   <= '0;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_cnt_d   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // the emit step does its own handoff of the output register
            if (r_o_valid && i_ready && r_state != S_EMIT) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cur_a <= w_ext_a[SAMPLE_BITS-1:0];
                        r_cur_b <= w_ext_b[SAMPLE_BITS-1:0];
                        r_last  <= i_last_in_block;
                        r_state <= S_CROSS_A;
                    end
                end
                S_CROSS_A: begin
                    if (w_xa) begin
                        if (r_cnt_a < COUNT_MAX) begin
                            r_sum_a <= n_sum_a;
                            r_cnt_a <= r_cnt_a + 1'b1;
                        end
                        r_ear_a <= r_lat_a;
                        r_state <= S_WAIT_A;
                    end else begin
                        r_state <= S_CROSS_B;
                    end
                end
                S_WAIT_A: begin
                    if (w_div_sts.done) begin
                        r_lat_a <= w_tcross;
                        r_state <= S_CROSS_B;
                    end
                end
                S_CROSS_B: begin
                    if (w_xb) begin
                        if (r_cnt_b < COUNT_MAX) begin
                            r_sum_b <= n_sum_b;
                            r_cnt_b <= r_cnt_b + 1'b1;
                        end
                        if (r_cnt_d < COUNT_MAX) begin
                            r_sum_d <= n_sum_d;
                            r_cnt_d <= r_cnt_d + 1'b1;
                        end
                        r_ear_b <= r_lat_b;
                        r_state <= S_WAIT_B;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_WAIT_B: begin
                    if (w_div_sts.done) begin
                        r_lat_b <= w_tcross;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_prev_a <= r_cur_a;
                    r_prev_b <= r_cur_b;
                    r_time   <= r_time + 1'b1;
                    r_state  <= r_last ? S_AVG_A : S_IDLE;
                end
                S_AVG_A: begin
                    r_state <= S_WAIT_PA;
                end
                S_WAIT_PA: begin
                    if (w_div_sts.done) begin
                        r_pa    <= w_sat_u;
                        r_state <= S_AVG_B;
                    end
                end
                S_AVG_B: begin
                    r_state <= S_WAIT_PB;
                end
                S_WAIT_PB: begin
                    if (w_div_sts.done) begin
                        r_pb    <= w_sat_u;
                        r_state <= S_AVG_D;
                    end
                end
                S_AVG_D: begin
                    r_state <= S_WAIT_DL;
                end
                S_WAIT_DL: begin
                    if (w_div_sts.done) begin
                        r_dl    <= w_sat_d;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // empty counts give zero and a cleared flag
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_pa    <= (r_cnt_a != '0) ? r_pa : '0;
                        r_o_pb    <= (r_cnt_b != '0) ? r_pb : '0;
                        r_o_dl    <= (r_cnt_d != '0) ? r_dl : '0;
                        r_o_va    <= (r_cnt_a != '0);
                        r_o_vb    <= (r_cnt_b != '0);
                        r_o_vd    <= (r_cnt_d != '0);
                        r_sum_a   <= '0;
                        r_sum_b   <= '0;
                        r_sum_d   <= '0;
                        r_cnt_a   <= '0;
                        r_cnt_b   <= '0;
                        r_cnt_d   <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_avg_period_a   = r_o_pa;
    assign o_avg_period_b   = r_o_pb;
    assign o_avg_delay      = r_o_dl;
    assign o_period_a_valid = r_o_va;
    assign o_period_b_valid = r_o_vb;
    assign o_delay_valid    = r_o_vd;

    // divider finishes only while the sequencer is waiting on it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_WAIT_A || r_state == S_WAIT_B
                         || r_state == S_WAIT_PA || r_state == S_WAIT_PB
                         || r_state == S_WAIT_DL))
        else $error("divider done outside a wait step");

    // a new result word only comes from the emit step
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_EMIT))
        else $error("result word raised outside emit");

    // counts stay within their saturation bound
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= COUNT_MAX) && (r_cnt_b <= COUNT_MAX) && (r_cnt_d <= COUNT_MAX))
        else $error("crossing count past its bound");

    // channel a's interpolated fraction never exceeds one sample
    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT_A && w_div_sts.done)
        |=> ((r_lat_a - w_tbase) <= (TIME_W'(1) << FRAC_BITS)))
        else $error("crossing fraction above one sample");

endmodule

`default_nettype wire

// ----- tb/zcpc_phase_checker.sv -----
// ----------------------------------------------------------------------------
// zcpc_phase_checker
// watches both channels of the zero-crossing phase comparator, tracks
// crossings, sums and counts on its own and compares every block average
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zcpc_phase_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_ready,
    input  wire logic signed [zcpc_pkg::IN_W-1:0]  i_sample_a,
    input  wire logic signed [zcpc_pkg::IN_W-1:0]  i_sample_b,
    input  wire logic                              i_last_in_block,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic [zcpc_pkg::OUT_W-1:0]        i_avg_period_a,
    input  wire logic [zcpc_pkg::OUT_W-1:0]        i_avg_period_b,
    input  wire logic signed [zcpc_pkg::OUT_W-1:0] i_avg_delay,
    input  wire logic                              i_period_a_valid,
    input  wire logic                              i_period_b_valid,
    input  wire logic                              i_delay_valid,
    output int                                     o_fail_count,
    output int                                     o_pending,
    output int                                     o_words,
    output int                                     o_results,
    output int                                     o_cross_a,
    output int                                     o_cross_b
);
    import zcpc_pkg::*;

    localparam int          FRAC      = FRAC_BITS_DEF;
    localparam int          CNT_W     = 13;
    localparam logic [12:0] CNT_SAT   = CNT_W'(2 * MAX_BLOCK_DEF - 1);
    localparam longint      PSUM_MAX  = (longint'(1) << SUM_W) - 1;
    localparam longint      DSUM_MAX  = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint      DSUM_MIN  = -DSUM_MAX - 1;
    localparam longint      AVG_U_MAX = (longint'(1) << OUT_W) - 1;
    localparam longint      AVG_S_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint      AVG_S_MIN = -AVG_S_MAX - 1;
    localparam int          SHOW_MAX  = 10;

    typedef struct packed {
        logic [OUT_W-1:0] period_a;
        logic [OUT_W-1:0] period_b;
        logic [OUT_W-1:0] delay;
        logic             a_ok;
        logic             b_ok;
        logic             delay_ok;
    } block_avg_t;

    // tracker state
    logic signed [IN_W-1:0] hist_a, hist_b;
    logic [TIME_W-1:0]      tick;
    logic [TIME_W-1:0]      a_new, a_old, b_new, b_old;
    longint                 sum_per_a, sum_per_b, sum_lag;
    logic [CNT_W-1:0]       n_a, n_b, n_lag;

    block_avg_t block_avgs_q[$];
    int fails, words_done, results_done, xa, xb;

    // interpolated crossing time, sample index plus -prev/(cur-prev)
    function automatic logic [TIME_W-1:0] crossing_time(int prev, int cur,
                                                        logic [TIME_W-1:0] at);
        int num, den;
        num = (-prev) << FRAC;
        den = cur - prev;
        return (at << FRAC) + TIME_W'(num / den);
    endfunction

    function automatic longint add_interval(longint sum, logic [TIME_W-1:0] d);
        longint s;
        s = sum + longint'(d);
        return (s > PSUM_MAX) ? PSUM_MAX : s;
    endfunction

    function automatic longint add_lag(longint sum, logic [TIME_W-1:0] d);
        longint s;
        s = sum + longint'($signed(d));
        if (s > DSUM_MAX) s = DSUM_MAX;
        if (s < DSUM_MIN) s = DSUM_MIN;
        return s;
    endfunction

    function automatic logic [OUT_W-1:0] mean_of(longint sum, logic [CNT_W-1:0] n,
                                                 longint lo, longint hi);
        longint q;
        if (n == 0) return '0;
        q = sum / longint'(n);
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return q[OUT_W-1:0];
    endfunction

    task automatic step_tracker(input logic signed [IN_W-1:0] a,
                                input logic signed [IN_W-1:0] b, input logic last);
        block_avg_t r;
        if (a >= 0 && hist_a < 0) begin
            if (n_a < CNT_SAT) begin
                sum_per_a = add_interval(sum_per_a, a_new - a_old);
                n_a++;
            end
            a_old = a_new;
            a_new = crossing_time(hist_a, a, tick);
            xa++;
        end
        // delay uses the previous b crossing against the newest a crossing
        if (b >= 0 && hist_b < 0) begin
            if (n_b < CNT_SAT) begin
                sum_per_b = add_interval(sum_per_b, b_new - b_old);
                n_b++;
            end
            b_old = b_new;
            if (n_lag < CNT_SAT) begin
                sum_lag = add_lag(sum_lag, b_new - a_new);
                n_lag++;
            end
            b_new = crossing_time(hist_b, b, tick);
            xb++;
        end
        hist_a = a;
        hist_b = b;
        tick++;
        if (last) begin
            r.period_a = mean_of(sum_per_a, n_a, 0, AVG_U_MAX);
            r.period_b = mean_of(sum_per_b, n_b, 0, AVG_U_MAX);
            r.delay    = mean_of(sum_lag, n_lag, AVG_S_MIN, AVG_S_MAX);
            r.a_ok     = (n_a != 0);
            r.b_ok     = (n_b != 0);
            r.delay_ok = (n_lag != 0);
            block_avgs_q.push_back(r);
            sum_per_a = 0;
            sum_per_b = 0;
            sum_lag   = 0;
            n_a       = '0;
            n_b       = '0;
            n_lag     = '0;
        end
    endtask

    task automatic check_result;
        block_avg_t want;
        bit         bad;
        results_done++;
        if (block_avgs_q.size() == 0) begin
            fails++;
            if (fails <= SHOW_MAX)
                $display("%0t: result word %0d arrived with none expected", $realtime,
                         results_done);
            return;
        end
        want = block_avgs_q.pop_front();
        bad = (i_avg_period_a !== want.period_a) || (i_avg_period_b !== want.period_b) ||
              (i_avg_delay !== want.delay) || (i_period_a_valid !== want.a_ok) ||
              (i_period_b_valid !== want.b_ok) || (i_delay_valid !== want.delay_ok);
        if (bad) begin
            fails++;
            if (fails <= SHOW_MAX) begin
                $display("%0t: result %0d expected pa=%0d pb=%0d dl=%0d ok=%b%b%b", $realtime,
                         results_done, want.period_a, want.period_b, $signed(want.delay),
                         want.a_ok, want.b_ok, want.delay_ok);
                $display("%0t: result %0d actual   pa=%0d pb=%0d dl=%0d ok=%b%b%b", $realtime,
                         results_done, i_avg_period_a, i_avg_period_b, i_avg_delay,
                         i_period_a_valid, i_period_b_valid, i_delay_valid);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hist_a       = '0;
            hist_b       = '0;
            tick         = '0;
            a_new        = '0;
            a_old        = '0;
            b_new        = '0;
            b_old        = '0;
            sum_per_a    = 0;
            sum_per_b    = 0;
            sum_lag      = 0;
            n_a          = '0;
            n_b          = '0;
            n_lag        = '0;
            block_avgs_q.delete();
            fails        = 0;
            words_done   = 0;
            results_done = 0;
            xa           = 0;
            xb           = 0;
        end else begin
            // a result can never stem from the word taken at the same edge
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready) begin
                step_tracker(i_sample_a, i_sample_b, i_last_in_block);
                words_done++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= block_avgs_q.size();
        o_words      <= words_done;
        o_results    <= results_done;
        o_cross_a    <= xa;
        o_cross_b    <= xb;
    end

endmodule

`default_nettype wire

// ----- tb/zero_crossing_phase_comparator_test.sv -----
// ----------------------------------------------------------------------------
// zero_crossing_phase_comparator_test
// stimulus and verdict for the zero-crossing phase comparator: directed edge
// samples, random sign-switching blocks with idling on both sides, and a
// closing stretch of short blocks with no idling at all
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zero_crossing_phase_comparator_test;
    import zcpc_pkg::*;

    localparam int LIMIT_CYCLES = 400_000;
    localparam int RANDOM_WORDS = 760;
    localparam int MIN_BLOCKS   = 40;
    localparam int TAIL_WORDS   = 60;         // closing words, blocks of 12
    localparam int DRAIN_CYCLES = 200;        // worst word plus averaging tail

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [IN_W-1:0]  i_sample_a;
    logic signed [IN_W-1:0]  i_sample_b;
    logic                    i_last_in_block;
    logic                    o_valid;
    logic                    i_ready;
    logic [OUT_W-1:0]        o_avg_period_a;
    logic [OUT_W-1:0]        o_avg_period_b;
    logic signed [OUT_W-1:0] o_avg_delay;
    logic                    o_period_a_valid;
    logic                    o_period_b_valid;
    logic                    o_delay_valid;

    int fail_count, pending, words_seen, results_seen, cross_a, cross_b;
    int tx_gap_pct   = 0;   // chance of a sender gap before a word
    int rx_stall_pct = 0;   // chance of a receiver stall burst per cycle
    int rx_hold;
    int cycle_count;

    zero_crossing_phase_comparator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_a      (i_sample_a),
        .i_sample_b      (i_sample_b),
        .i_last_in_block (i_last_in_block),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_avg_period_a  (o_avg_period_a),
        .o_avg_period_b  (o_avg_period_b),
        .o_avg_delay     (o_avg_delay),
        .o_period_a_valid(o_period_a_valid),
        .o_period_b_valid(o_period_b_valid),
        .o_delay_valid   (o_delay_valid)
    );

    zcpc_phase_checker u_phase_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_sample_a      (i_sample_a),
        .i_sample_b      (i_sample_b),
        .i_last_in_block (i_last_in_block),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_avg_period_a  (o_avg_period_a),
        .i_avg_period_b  (o_avg_period_b),
        .i_avg_delay     (o_avg_delay),
        .i_period_a_valid(o_period_a_valid),
        .i_period_b_valid(o_period_b_valid),
        .i_delay_valid   (o_delay_valid),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words         (words_seen),
        .o_results       (results_seen),
        .o_cross_a       (cross_a),
        .o_cross_b       (cross_b)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog, counts rising edges until the limit
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles with %0d results still due", cycle_count,
                 pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: ready drops in random bursts while stalls are enabled
    initial begin
        i_ready = 1'b0;
        rx_hold = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                rx_hold = $urandom_range(0, 7);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // one word on the input channel; entered and left at a falling edge
    task automatic push_word(input logic signed [IN_W-1:0] a,
                             input logic signed [IN_W-1:0] b, input logic last);
        int gap;
        gap = 0;
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct)
            gap = $urandom_range(1, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sample_a      <= a;
        i_sample_b      <= b;
        i_last_in_block <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender goes quiet until every block average has come back
    task automatic wait_for_results;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // sample with a chosen sign: extremes, values near zero, or anything
    function automatic logic signed [IN_W-1:0] shaped_sample(bit neg);
        case ($urandom_range(0, 7))
            0:       return neg ? -16'sd32768 : 16'sd32767;
            1:       return neg ? -16'sd1 : 16'sd0;
            2:       return neg ? IN_W'(-int'($urandom_range(1, 4)))
                                : IN_W'($urandom_range(0, 4));
            default: return neg ? IN_W'(-int'($urandom_range(1, 32768)))
                                : IN_W'($urandom_range(0, 32767));
        endcase
    endfunction

    initial begin
        int                     blk_len, rnd_words, rnd_blocks, flip_a, flip_b;
        bit                     neg_a, neg_b;
        logic signed [IN_W-1:0] sa, sb;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_sample_a      = '0;
        i_sample_b      = '0;
        i_last_in_block = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---------------- directed words ----------------
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        // block with no crossing at all: zero averages, flags low
        push_word(16'sd0, 16'sd0, 1'b1);
        // extreme negative, then a crossing onto exactly zero (fraction 1.0)
        // on a and from -1 up to full scale (fraction 0) on b
        push_word(-16'sd32768, -16'sd1, 1'b0);
        push_word(16'sd0, 16'sd32767, 1'b0);
        // full swing on a, crossing onto zero on b; second crossing on each channel after reset
        push_word(-16'sd32768, -16'sd32768, 1'b0);
        push_word(16'sd32767, 16'sd0, 1'b1);
        // tiny steps across zero
        push_word(-16'sd1, -16'sd1, 1'b0);
        push_word(16'sd0, 16'sd0, 1'b0);
        push_word(-16'sd1, -16'sd1, 1'b0);
        push_word(16'sd1, 16'sd32767, 1'b1);
        // single-word block
        push_word(16'sd32767, -16'sd32768, 1'b1);
        // mixed small and extreme swings
        push_word(-16'sd2, 16'sd5, 1'b0);
        push_word(16'sd3, -16'sd7, 1'b0);
        push_word(-16'sd32768, 16'sd32767, 1'b0);
        push_word(16'sd32767, -16'sd32768, 1'b1);
        // a crosses twice, b once on the first word: all three averages stay valid
        push_word(-16'sd5, 16'sd100, 1'b0);
        push_word(16'sd5, 16'sd100, 1'b0);
        push_word(-16'sd5, 16'sd100, 1'b0);
        push_word(16'sd5, 16'sd100, 1'b1);
        // b crosses alone: a period invalid, delay still measured
        push_word(16'sd100, -16'sd5, 1'b0);
        push_word(16'sd100, 16'sd5, 1'b1);

        // ---------------- random blocks ----------------
        rnd_words  = 0;
        rnd_blocks = 0;
        neg_a      = 1'b0;
        neg_b      = 1'b0;
        while (rnd_words < RANDOM_WORDS || rnd_blocks < MIN_BLOCKS) begin
            blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 24);
            // per-channel sign flip rate; a silent channel now and then
            flip_a = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
            flip_b = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
            tx_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            for (int k = 0; k < blk_len; k++) begin
                if (flip_a != 0 && $urandom_range(0, flip_a - 1) == 0) neg_a = !neg_a;
                if (flip_b != 0 && $urandom_range(0, flip_b - 1) == 0) neg_b = !neg_b;
                if ($urandom_range(0, 7) == 0) begin
                    // plain noise word
                    sa = IN_W'($urandom);
                    sb = IN_W'($urandom);
                end else begin
                    sa = shaped_sample(neg_a);
                    sb = shaped_sample(neg_b);
                end
                push_word(sa, sb, k == blk_len - 1);
                rnd_words++;
            end
            rnd_blocks++;
            // halfway through, let the pipeline empty once
            if (rnd_blocks == MIN_BLOCKS / 2)
                wait_for_results();
        end

        // ---------------- closing blocks ----------------
        // no idling from here on
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        for (int k = 0; k < TAIL_WORDS; k++) begin
            sa = shaped_sample(k[0] == 1'b0);
            sb = shaped_sample(k[1] == 1'b0);
            push_word(sa, sb, ((k % 12) == 11) || (k == TAIL_WORDS - 1));
        end
        // short block afterwards shows the counts were cleared
        push_word(-16'sd1, -16'sd1, 1'b0);
        push_word(16'sd0, 16'sd0, 1'b1);

        // ---------------- wrap up ----------------
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("run covered %0d words and %0d block averages, %0d a and %0d b crossings",
                 words_seen, results_seen, cross_a, cross_b);
        $display("including directed edge samples, stalls on both sides and %0d closing words",
                 TAIL_WORDS);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
